FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/rotsp_pkg.sv
// ----------------------------------------------------------------------------
// Rotation sine packetizer package
// Register map, transaction codes, reset values and shared structs.
// ----------------------------------------------------------------------------
package rotsp_pkg;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic signed [31:0] COS_COEFF_RESET = 32'sd848008007;
   localparam logic signed [31:0] SIN_COEFF_RESET = 32'sd658637529;
   localparam logic [9:0]         SAMPLES_PER_PACKET_RESET = 10'd89;

   localparam logic signed [15:0] SAMPLE_PEAK = 16'sd32767;

   typedef enum logic [1:0] {
      REG_COS_COEFF          = 2'd0,
      REG_SIN_COEFF          = 2'd1,
      REG_SAMPLES_PER_PACKET = 2'd2
   } reg_index_type;

   typedef enum logic {
      KIND_GENERATE = 1'b0,
      KIND_ARM      = 1'b1
   } kind_type;

   typedef struct packed {
      logic signed [31:0] cos_coeff;
      logic signed [31:0] sin_coeff;
      logic [9:0]         samples_per_packet;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               packet_last;
      logic               probe_tap;
      logic               probe_done;
   } result_type;

endpackage

FILE: hw/rtl/rotsp_if.sv
// ----------------------------------------------------------------------------
// Rotation sine packetizer channels
// Valid/ready request and response channels with their payload.
// ----------------------------------------------------------------------------
interface rotsp_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] probe_count;

   modport source (output valid, output kind, output probe_count, input ready);
   modport sink   (input valid, input kind, input probe_count, output ready);
endinterface

interface rotsp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               packet_last;
   logic               probe_tap;
   logic               probe_done;

   modport source (output valid, output sample, output packet_last, output probe_tap,
                   output probe_done, input ready);
   modport sink   (input valid, input sample, input packet_last, input probe_tap,
                   input probe_done, output ready);
endinterface

FILE: hw/rtl/rotsp_csr.sv
// ----------------------------------------------------------------------------
// Rotation sine packetizer register file
// APB-style access to the rotation coefficients and the packet length.
// ----------------------------------------------------------------------------
module rotsp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rotsp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [rotsp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [rotsp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                  csr_pready,
   output rotsp_pkg::cfg_type                    cfg
);

   rotsp_pkg::cfg_type       cfg_ff;
   rotsp_pkg::cfg_type       cfg_in;
   rotsp_pkg::reg_index_type reg_index;
   logic                     wr_en;

   assign reg_index  = rotsp_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            rotsp_pkg::REG_COS_COEFF:          cfg_in.cos_coeff = $signed(csr_pwdata);
            rotsp_pkg::REG_SIN_COEFF:          cfg_in.sin_coeff = $signed(csr_pwdata);
            rotsp_pkg::REG_SAMPLES_PER_PACKET: cfg_in.samples_per_packet = csr_pwdata[9:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         rotsp_pkg::REG_COS_COEFF:          csr_prdata = cfg_ff.cos_coeff;
         rotsp_pkg::REG_SIN_COEFF:          csr_prdata = cfg_ff.sin_coeff;
         rotsp_pkg::REG_SAMPLES_PER_PACKET: csr_prdata = {22'd0, cfg_ff.samples_per_packet};
         default:                           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_coeff          <= rotsp_pkg::COS_COEFF_RESET;
         cfg_ff.sin_coeff          <= rotsp_pkg::SIN_COEFF_RESET;
         cfg_ff.samples_per_packet <= rotsp_pkg::SAMPLES_PER_PACKET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/rotsp_osc.sv
// ----------------------------------------------------------------------------
// Rotation sine packetizer oscillator core
// Phasor rotation, sample scaling, packet counting and probe tracking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotsp_osc #(
   parameter int COEFF_FRAC_BITS    = 30,
   parameter int MAX_PACKET_SAMPLES = 1000
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rotsp_pkg::cfg_type    cfg,
   input  logic                  item_accept,
   input  logic                  item_kind,
   input  logic [15:0]           item_probe_count,
   output logic                  result_push,
   output rotsp_pkg::result_type result
);

   localparam logic signed [31:0] PHASE_ONE  = 32'sd1 <<< COEFF_FRAC_BITS;
   localparam logic signed [65:0] ROUND_HALF = 66'sd1 <<< (COEFF_FRAC_BITS - 1);
   localparam logic signed [47:0] TRUNC_BIAS = (48'sd1 <<< COEFF_FRAC_BITS) - 48'sd1;
   localparam logic [9:0]         MAX_LEN    = 10'(MAX_PACKET_SAMPLES);
   localparam logic signed [47:0] SMP_MAX    = 48'(rotsp_pkg::SAMPLE_PEAK);
   localparam logic signed [47:0] SMP_MIN    = -48'(rotsp_pkg::SAMPLE_PEAK);

   logic signed [31:0] phase_x_ff, phase_x_in;
   logic signed [31:0] phase_y_ff, phase_y_in;
   logic [9:0]         packet_fill_ff, packet_fill_in;
   logic               probe_active_ff, probe_active_in;
   logic [15:0]        probe_remaining_ff, probe_remaining_in;

   logic               gen, arm;
   logic signed [31:0] coef_c, coef_s;
   logic signed [63:0] prod_xc, prod_ys, prod_xs, prod_yc;
   logic signed [65:0] sum_x, sum_y;
   logic signed [65:0] shr_x, shr_y;
   logic signed [47:0] smp_scaled, smp_trunc;
   logic signed [15:0] smp_sat;
   logic [9:0]         pkt_len;
   logic [9:0]         fill_next;
   logic               last;
   logic               tap, done;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic [34:0] hi;
      hi = v[65:31];
      if ((&hi) || (~|hi)) begin
         return v[31:0];
      end else if (v[65]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7fff_ffff;
      end
   endfunction

   assign gen = item_accept && (item_kind == rotsp_pkg::KIND_GENERATE);
   assign arm = item_accept && (item_kind == rotsp_pkg::KIND_ARM);

   assign coef_c = cfg.cos_coeff;
   assign coef_s = cfg.sin_coeff;

   // rotation: x' = x*c - y*s, y' = x*s + y*c, round half up
   assign prod_xc = phase_x_ff * coef_c;
   assign prod_ys = phase_y_ff * coef_s;
   assign prod_xs = phase_x_ff * coef_s;
   assign prod_yc = phase_y_ff * coef_c;

   assign sum_x = 66'(prod_xc) - 66'(prod_ys) + ROUND_HALF;
   assign sum_y = 66'(prod_xs) + 66'(prod_yc) + ROUND_HALF;
   assign shr_x = sum_x >>> COEFF_FRAC_BITS;
   assign shr_y = sum_y >>> COEFF_FRAC_BITS;

   // 32767*y as shift and subtract, truncated toward zero
   assign smp_scaled = (48'(phase_y_ff) <<< 15) - 48'(phase_y_ff);
   assign smp_trunc  = (smp_scaled + (smp_scaled[47] ? TRUNC_BIAS : 48'sd0))
                       >>> COEFF_FRAC_BITS;

   always_comb begin
      if (smp_trunc > SMP_MAX) begin
         smp_sat = rotsp_pkg::SAMPLE_PEAK;
      end else if (smp_trunc < SMP_MIN) begin
         smp_sat = -rotsp_pkg::SAMPLE_PEAK;
      end else begin
         smp_sat = smp_trunc[15:0];
      end
   end

   always_comb begin
      if (cfg.samples_per_packet == 10'd0) begin
         pkt_len = 10'd1;
      end else if (cfg.samples_per_packet > MAX_LEN) begin
         pkt_len = MAX_LEN;
      end else begin
         pkt_len = cfg.samples_per_packet;
      end
   end

   assign fill_next = packet_fill_ff + 10'd1;
   assign last      = fill_next >= pkt_len;

   assign tap  = probe_active_ff;
   assign done = probe_active_ff && (probe_remaining_ff <= 16'd1);

   always_comb begin
      phase_x_in         = phase_x_ff;
      phase_y_in         = phase_y_ff;
      packet_fill_in     = packet_fill_ff;
      probe_active_in    = probe_active_ff;
      probe_remaining_in = probe_remaining_ff;
      if (arm) begin
         probe_active_in    = 1'b1;
         probe_remaining_in = item_probe_count;
      end else if (gen) begin
         phase_x_in     = sat32(shr_x);
         phase_y_in     = sat32(shr_y);
         packet_fill_in = last ? 10'd0 : fill_next;
         if (done) begin
            probe_active_in    = 1'b0;
            probe_remaining_in = 16'd0;
         end else if (probe_active_ff) begin
            probe_remaining_in = probe_remaining_ff - 16'd1;
         end
      end
   end

   assign result_push        = gen;
   assign result.sample      = smp_sat;
   assign result.packet_last = last;
   assign result.probe_tap   = tap;
   assign result.probe_done  = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_x_ff         <= PHASE_ONE;
         phase_y_ff         <= 32'sd0;
         packet_fill_ff     <= 10'd0;
         probe_active_ff    <= 1'b0;
         probe_remaining_ff <= 16'd0;
      end else begin
         phase_x_ff         <= phase_x_in;
         phase_y_ff         <= phase_y_in;
         packet_fill_ff     <= packet_fill_in;
         probe_active_ff    <= probe_active_in;
         probe_remaining_ff <= probe_remaining_in;
      end
   end

   `ASSERT_HOLDS(a_idle_probe_clear, clock, reset,
                 probe_active_ff || (probe_remaining_ff == 16'd0), "probe count left while idle")
   `ASSERT_HOLDS(a_fill_below_max, clock, reset,
                 packet_fill_ff < MAX_LEN, "packet fill beyond max length")
   `ASSERT_NEXT(a_arm_starts_probe, clock, reset,
                arm, probe_active_ff, "arm did not start probe")

endmodule

FILE: hw/rtl/rotsp_skid.sv
// ----------------------------------------------------------------------------
// Rotation sine packetizer output buffer
// Result register with a skid entry so a result can still be taken under back-pressure.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotsp_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rotsp_pkg::result_type push_data,
   output logic                  can_accept,
   rotsp_rsp_if.source           rsp_if
);

   logic                  out_valid_ff, out_valid_in;
   rotsp_pkg::result_type out_data_ff, out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   rotsp_pkg::result_type skid_data_ff, skid_data_in;
   logic                  pop;

   assign pop        = out_valid_ff && rsp_if.ready;
   assign can_accept = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         // skid entry drains first; no push can arrive while it is full
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.sample      = out_data_ff.sample;
   assign rsp_if.packet_last = out_data_ff.packet_last;
   assign rsp_if.probe_tap   = out_data_ff.probe_tap;
   assign rsp_if.probe_done  = out_data_ff.probe_done;

   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid full with output empty")
   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push, !skid_valid_ff, "push into full buffer")
   `ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && pop, out_valid_ff && !skid_valid_ff, "skid entry not moved to output")

endmodule

FILE: hw/rtl/rotation_sine_packetizer.sv
// A generate result reaches rsp_if through the output register, or through the skid
// entry while the output is held. Throughput: one transaction per clock while the skid
// entry is empty; the phasor rotation through four multipliers is combinational. Arm
// transactions give no result. Synchronous reset restores the coefficients, phase
// (1, 0), packet fill and probe state, and empties the two-entry result buffer.
// ----------------------------------------------------------------------------
// Rotation sine packetizer
// Coupled-form sine oscillator with packet framing and a probe tap.
// ----------------------------------------------------------------------------
module rotation_sine_packetizer #(
   parameter int COEFF_FRAC_BITS    = 30,
   parameter int MAX_PACKET_SAMPLES = 1000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   rotsp_req_if.sink                             req_if,
   rotsp_rsp_if.source                           rsp_if,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [rotsp_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [rotsp_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [rotsp_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                  csr_pready
);

   rotsp_pkg::cfg_type    cfg;
   rotsp_pkg::result_type result;
   logic                  result_push;
   logic                  can_accept;
   logic                  item_accept;

   assign req_if.ready = can_accept;
   assign item_accept  = req_if.valid && can_accept;

   rotsp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rotsp_osc #(
      .COEFF_FRAC_BITS    (COEFF_FRAC_BITS),
      .MAX_PACKET_SAMPLES (MAX_PACKET_SAMPLES)
   ) u_osc (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .item_accept      (item_accept),
      .item_kind        (req_if.kind),
      .item_probe_count (req_if.probe_count),
      .result_push      (result_push),
      .result           (result)
   );

   rotsp_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (result_push),
      .push_data  (result),
      .can_accept (can_accept),
      .rsp_if     (rsp_if)
   );

endmodule

FILE: verif/tb_rotation_sine_packetizer.sv
// ----------------------------------------------------------------------------
// Rotation sine packetizer testbench
// Drives generate and arm transactions through the request channel, and
// reprograms the coefficients and packet length over the register port
// between runs. Each result is checked against a bit-exact oscillator model kept
// in the bench or against the values a directed row gives. A short directed table
// comes first, then random runs, most with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_rotation_sine_packetizer;

   localparam int COEFF_FRAC_BITS    = 30;
   localparam int MAX_PACKET_SAMPLES = 1000;
   localparam int NUM_RUNS           = 8;
   localparam int ITEMS_PER_RUN      = 60;

   localparam logic signed [31:0] Q_ONE    = 32'sd1073741824;
   localparam logic signed [65:0] HALF_LSB = 66'sd536870912;
   localparam logic signed [65:0] Q_MAX    = 66'sd2147483647;
   localparam logic signed [65:0] Q_MIN    = -66'sd2147483648;

   typedef enum logic {
      STEP_ITEM = 1'b0,
      STEP_CSR  = 1'b1
   } step_op_type;

   typedef struct packed {
      step_op_type              op;
      rotsp_pkg::reg_index_type index;
      logic [31:0]              value;
      rotsp_pkg::kind_type      kind;
      logic [15:0]              count;
      logic                     typed;
      rotsp_pkg::result_type    want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [rotsp_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [rotsp_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [rotsp_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;

   rotsp_req_if req_if ();
   rotsp_rsp_if rsp_if ();

   // oscillator model state and its copy of the registers
   logic signed [31:0] osc_x;
   logic signed [31:0] osc_y;
   logic [9:0]         frame_fill;
   logic               probe_armed;
   logic [15:0]        probe_left;
   logic signed [31:0] cfg_cos;
   logic signed [31:0] cfg_sin;
   logic [9:0]         cfg_len;

   rotsp_pkg::result_type predicted_samples[$];
   logic                  drv_typed;
   rotsp_pkg::result_type drv_want;
   int unsigned           idle_pct;
   int unsigned           mismatch_count = 0;

   // cos = 0, sin = 1.0 turns the phasor a quarter per sample, so the samples
   // there can be read off directly
   directed_row_type directed_rows [0:29] = '{
      '{STEP_CSR,  rotsp_pkg::REG_COS_COEFF, 32'h0000_0000, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_CSR,  rotsp_pkg::REG_SIN_COEFF, 32'h4000_0000, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_CSR,  rotsp_pkg::REG_SAMPLES_PER_PACKET, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'hFFFF,
        1'b1, '{16'sd0, 1'b1, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b1, '{16'sd32767, 1'b1, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_ARM,      16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b1, '{16'sd0, 1'b1, 1'b1, 1'b1}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b1, '{-16'sd32767, 1'b1, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_ARM,      16'h0003,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b1, '{16'sd0, 1'b1, 1'b1, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b1, '{16'sd32767, 1'b1, 1'b1, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_ARM,      16'h0001,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b1, '{16'sd0, 1'b1, 1'b1, 1'b1}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b1, '{-16'sd32767, 1'b1, 1'b0, 1'b0}},
      '{STEP_CSR,  rotsp_pkg::REG_SAMPLES_PER_PACKET, 32'd1023, rotsp_pkg::KIND_GENERATE,
        16'h0000, 1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_CSR,  rotsp_pkg::REG_COS_COEFF, 32'hC000_0000, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_CSR,  rotsp_pkg::REG_SIN_COEFF, 32'hC000_0000, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_ARM,      16'hFFFF,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h5555,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'hAAAA,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_CSR,  rotsp_pkg::REG_SAMPLES_PER_PACKET, 32'd2, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_CSR,  rotsp_pkg::REG_COS_COEFF, 32'h2000_0000, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_CSR,  rotsp_pkg::REG_SIN_COEFF, 32'h2000_0000, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}},
      '{STEP_ITEM, rotsp_pkg::REG_COS_COEFF, 32'd0, rotsp_pkg::KIND_GENERATE, 16'h0000,
        1'b0, '{16'sd0, 1'b0, 1'b0, 1'b0}}
   };

   rotation_sine_packetizer #(
      .COEFF_FRAC_BITS    (COEFF_FRAC_BITS),
      .MAX_PACKET_SAMPLES (MAX_PACKET_SAMPLES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round half up, then clip to the 32-bit phasor range
   function automatic logic signed [31:0] round_to_q30(input logic signed [65:0] acc);
      logic signed [65:0] r;
      r = (acc + HALF_LSB) >>> COEFF_FRAC_BITS;
      if (r > Q_MAX)
         r = Q_MAX;
      if (r < Q_MIN)
         r = Q_MIN;
      return r[31:0];
   endfunction

   // emits the sample for the current phasor, then rotates it and advances
   // the packet and probe counters
   function automatic rotsp_pkg::result_type next_sample();
      rotsp_pkg::result_type r;
      logic signed [65:0]    acc;
      logic signed [31:0]    nx;
      logic signed [31:0]    ny;
      logic [9:0]            len;
      acc = osc_y * rotsp_pkg::SAMPLE_PEAK;
      if (acc >= 0)
         acc = acc >>> COEFF_FRAC_BITS;
      else
         acc = -((-acc) >>> COEFF_FRAC_BITS);
      if (acc > rotsp_pkg::SAMPLE_PEAK)
         acc = rotsp_pkg::SAMPLE_PEAK;
      if (acc < -rotsp_pkg::SAMPLE_PEAK)
         acc = -rotsp_pkg::SAMPLE_PEAK;
      r.sample     = acc[15:0];
      r.probe_tap  = probe_armed;
      r.probe_done = 1'b0;
      if (probe_armed) begin
         if (probe_left <= 16'd1) begin
            r.probe_done = 1'b1;
            probe_armed  = 1'b0;
            probe_left   = 16'd0;
         end else begin
            probe_left = probe_left - 16'd1;
         end
      end
      acc = osc_x * cfg_cos - osc_y * cfg_sin;
      nx  = round_to_q30(acc);
      acc = osc_x * cfg_sin + osc_y * cfg_cos;
      ny  = round_to_q30(acc);
      osc_x = nx;
      osc_y = ny;
      len = cfg_len;
      if (len == 10'd0)
         len = 10'd1;
      if (len > 10'(MAX_PACKET_SAMPLES))
         len = 10'(MAX_PACKET_SAMPLES);
      frame_fill    = frame_fill + 10'd1;
      r.packet_last = 1'b0;
      if (frame_fill >= len) begin
         r.packet_last = 1'b1;
         frame_fill    = 10'd0;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rotsp_pkg::result_type predicted;
      rotsp_pkg::result_type want;
      if (reset) begin
         osc_x       = Q_ONE;
         osc_y       = 32'sd0;
         frame_fill  = 10'd0;
         probe_armed = 1'b0;
         probe_left  = 16'd0;
         cfg_cos     = rotsp_pkg::COS_COEFF_RESET;
         cfg_sin     = rotsp_pkg::SIN_COEFF_RESET;
         cfg_len     = rotsp_pkg::SAMPLES_PER_PACKET_RESET;
         predicted_samples.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (rotsp_pkg::reg_index_type'(csr_paddr[3:2]))
               rotsp_pkg::REG_COS_COEFF:          cfg_cos = csr_pwdata;
               rotsp_pkg::REG_SIN_COEFF:          cfg_sin = csr_pwdata;
               rotsp_pkg::REG_SAMPLES_PER_PACKET: cfg_len = csr_pwdata[9:0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            if (rotsp_pkg::kind_type'(req_if.kind) == rotsp_pkg::KIND_ARM) begin
               probe_armed = 1'b1;
               probe_left  = req_if.probe_count;
            end else begin
               predicted = next_sample();
               predicted_samples.insert(predicted_samples.size(),
                                        drv_typed ? drv_want : predicted);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_samples.size() == 0) begin
               $error("result with no transaction pending: sample %0d", rsp_if.sample);
               mismatch_count++;
            end else begin
               want = predicted_samples.pop_front();
               check_field("sample", want.sample, rsp_if.sample);
               check_field("packet_last", want.packet_last, rsp_if.packet_last);
               check_field("probe_tap", want.probe_tap, rsp_if.probe_tap);
               check_field("probe_done", want.probe_done, rsp_if.probe_done);
            end
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   // all three start and end on a falling edge with nothing yet assigned there
   task automatic send_item(input rotsp_pkg::kind_type kind, input logic [15:0] count,
                            input logic typed, input rotsp_pkg::result_type want);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.probe_count <= count;
      drv_typed          <= typed;
      drv_want           <= want;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (predicted_samples.size() != 0)
         @(negedge clock);
      // an arm transaction may still be in flight
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(input rotsp_pkg::reg_index_type index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1)
         @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      real                 angle;
      logic [31:0]         cos_v;
      logic [31:0]         sin_v;
      logic [9:0]          len_v;
      rotsp_pkg::kind_type kind_v;
      logic [15:0]         count_v;
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_if.valid       = 1'b0;
      req_if.kind        = rotsp_pkg::KIND_GENERATE;
      req_if.probe_count = 16'd0;
      drv_typed          = 1'b0;
      drv_want           = '0;
      idle_pct           = 20;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].op == STEP_CSR) begin
            drain_results();
            csr_write(directed_rows[r].index, directed_rows[r].value);
         end else begin
            send_item(directed_rows[r].kind, directed_rows[r].count, directed_rows[r].typed,
                      directed_rows[r].want);
         end
      end

      for (int run = 0; run < NUM_RUNS; run++) begin
         drain_results();
         if (run < NUM_RUNS - 2) begin
            // near-unit rotation keeps the amplitude around full scale
            angle = $urandom_range(0, 62831) / 10000.0;
            cos_v = $rtoi($cos(angle) * 1073741824.0);
            sin_v = $rtoi($sin(angle) * 1073741824.0);
         end else if (run == NUM_RUNS - 2) begin
            cos_v = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
            sin_v = $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
         end else begin
            cos_v = 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824);
            sin_v = 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824);
         end
         case (run)
            0:       len_v = 10'd1;
            1:       len_v = 10'(MAX_PACKET_SAMPLES);
            default: begin
               case ($urandom_range(0, 4))
                  0:       len_v = 10'd0;
                  1:       len_v = 10'($urandom_range(MAX_PACKET_SAMPLES + 1, 1023));
                  2:       len_v = 10'($urandom_range(9, MAX_PACKET_SAMPLES));
                  default: len_v = 10'($urandom_range(2, 8));
               endcase
            end
         endcase
         csr_write(rotsp_pkg::REG_COS_COEFF, cos_v);
         csr_write(rotsp_pkg::REG_SIN_COEFF, sin_v);
         csr_write(rotsp_pkg::REG_SAMPLES_PER_PACKET, {22'd0, len_v});
         // no idling in one early run and in the closing runs
         idle_pct = (run == 1 || run >= NUM_RUNS - 2) ? 0 : $urandom_range(5, 30);
         for (int n = 0; n < ITEMS_PER_RUN; n++) begin
            if (n == ITEMS_PER_RUN / 2 && $urandom_range(0, 1))
               drain_results();
            kind_v = ($urandom_range(0, 99) < 12) ? rotsp_pkg::KIND_ARM
                                                  : rotsp_pkg::KIND_GENERATE;
            if (kind_v == rotsp_pkg::KIND_ARM && $urandom_range(0, 1))
               count_v = 16'($urandom_range(0, 6));
            else
               count_v = 16'($urandom_range(0, 65535));
            send_item(kind_v, count_v, 1'b0, '0);
         end
      end

      req_if.valid <= 1'b0;
      for (int n = 0; n < 4000 && predicted_samples.size() != 0; n++)
         @(negedge clock);
      if (predicted_samples.size() != 0) begin
         $error("%0d transactions never produced a result", predicted_samples.size());
         mismatch_count++;
      end
      repeat (4) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
